@@ rtl/core/stencil_depth_fragment_test_defines.svh @@
// Assertion macros for the stencil/depth test block.
// Each macro checks an implication on the rising edge of clk, off while rst_n is low.
`ifndef STENCIL_DEPTH_FRAGMENT_TEST_DEFINES_SVH
`define STENCIL_DEPTH_FRAGMENT_TEST_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SDFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdft same-cycle check failed");

// Next-cycle implication.
`define SDFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdft next-cycle check failed");

`else

`define SDFT_ASSERT_NOW(label, ante, cons)
`define SDFT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/sdft_pkg.sv @@
`default_nettype none

package sdft_pkg;

    localparam int DEPTH_BITS_DEF = 24;
    localparam int APB_ADDR_BITS  = 5;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [7:0] STENCIL_MAX = 8'hFF;

    typedef enum logic [2:0] {
        REG_STENCIL_ENABLE  = 3'd0,
        REG_STENCIL_FUNC    = 3'd1,
        REG_STENCIL_REF     = 3'd2,
        REG_FRONT_OPS       = 3'd3,
        REG_BACK_OPS        = 3'd4,
        REG_WRITE_BLOCK     = 3'd5,
        REG_BUFFERS_PRESENT = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        FUNC_NEVER    = 3'd0,
        FUNC_LESS     = 3'd1,
        FUNC_LEQUAL   = 3'd2,
        FUNC_GREATER  = 3'd3,
        FUNC_GEQUAL   = 3'd4,
        FUNC_EQUAL    = 3'd5,
        FUNC_NOTEQUAL = 3'd6,
        FUNC_ALWAYS   = 3'd7
    } sfunc_t;

    typedef enum logic [2:0] {
        OP_KEEP      = 3'd0,
        OP_ZERO      = 3'd1,
        OP_REPLACE   = 3'd2,
        OP_INCR      = 3'd3,
        OP_INCR_WRAP = 3'd4,
        OP_DECR      = 3'd5,
        OP_DECR_WRAP = 3'd6,
        OP_INVERT    = 3'd7
    } sop_t;

    typedef enum logic [1:0] {
        FATE_STENCIL_FAIL = 2'd0,
        FATE_DEPTH_FAIL   = 2'd1,
        FATE_DISCARDED    = 2'd2,
        FATE_WRITTEN      = 2'd3
    } fate_t;

    // Write-block and buffer-present bit positions.
    localparam int WB_STENCIL = 0;
    localparam int WB_DEPTH   = 1;
    localparam int WB_COLOR   = 2;
    localparam int BP_STENCIL = 0;
    localparam int BP_DEPTH   = 1;

    typedef struct packed {
        logic       stencil_enable;
        sfunc_t     stencil_func;
        logic [7:0] stencil_ref;
        logic [8:0] front_ops;
        logic [8:0] back_ops;
        logic [2:0] write_block;
        logic [1:0] buffers_present;
    } sdft_cfg_t;

    typedef struct packed {
        fate_t      fate;
        logic [7:0] new_stencil;
        logic       stencil_write;
        logic       depth_write;
        logic       color_write;
    } sdft_result_t;

    function automatic logic stencil_compare(logic [7:0] s, logic [7:0] r, sfunc_t fn);
        logic pass;
        unique case (fn)
            FUNC_NEVER:    pass = 1'b0;
            FUNC_LESS:     pass = (s <  r);
            FUNC_LEQUAL:   pass = (s <= r);
            FUNC_GREATER:  pass = (s >  r);
            FUNC_GEQUAL:   pass = (s >= r);
            FUNC_EQUAL:    pass = (s == r);
            FUNC_NOTEQUAL: pass = (s != r);
            FUNC_ALWAYS:   pass = 1'b1;
            default:       pass = 1'b1;
        endcase
        return pass;
    endfunction

    function automatic logic [7:0] stencil_apply(logic [7:0] cur, sop_t op, logic [7:0] r);
        logic [7:0] res;
        unique case (op)
            OP_KEEP:      res = cur;
            OP_ZERO:      res = 8'd0;
            OP_REPLACE:   res = r;
            OP_INCR:      res = (cur == STENCIL_MAX) ? STENCIL_MAX : cur + 8'd1;
            OP_INCR_WRAP: res = cur + 8'd1;
            OP_DECR:      res = (cur == 8'd0) ? 8'd0 : cur - 8'd1;
            OP_DECR_WRAP: res = cur - 8'd1;
            OP_INVERT:    res = ~cur;
            default:      res = cur;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/stencil_depth_fragment_test.sv @@
// An accepted beat goes through the input register, then the result register.
// Throughput: one fragment per cycle unless out_ready stalls; the input and result
//   registers form a two-entry pipeline, so a new beat is taken while a result waits.
// Reset (rst_n low, asynchronous): both pipeline stages empty, configuration
//   registers at enable 0, func always, ref 0, ops keep, no write block, both buffers.
`default_nettype none

`include "stencil_depth_fragment_test_defines.svh"

module stencil_depth_fragment_test #(
    parameter int DEPTH_BITS = sdft_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // APB configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [sdft_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [sdft_pkg::APB_DATA_BITS-1:0]    pwdata,
    output var  logic [sdft_pkg::APB_DATA_BITS-1:0]    prdata,
    output var  logic                                  pready,
    // Fragment input channel
    input  wire logic                                  in_valid,
    output var  logic                                  in_ready,
    input  wire logic [7:0]                            stored_stencil,
    input  wire logic signed [DEPTH_BITS-1:0]          stored_depth,
    input  wire logic signed [DEPTH_BITS-1:0]          frag_depth,
    input  wire logic                                  front_facing,
    input  wire logic                                  shader_discard,
    // Result channel
    output var  logic                                  out_valid,
    input  wire logic                                  out_ready,
    output var  logic [1:0]                            fate,
    output var  logic [7:0]                            new_stencil,
    output var  logic                                  stencil_write,
    output var  logic                                  depth_write,
    output var  logic                                  color_write
);
    import sdft_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    sdft_cfg_t cfg_reg;
    logic      cfg_wr;
    reg_idx_t  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    // Registers sit on word boundaries; drop the byte offset.
    assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stencil_enable  <= 1'b0;
            cfg_reg.stencil_func    <= FUNC_ALWAYS;
            cfg_reg.stencil_ref     <= 8'd0;
            cfg_reg.front_ops       <= 9'd0;
            cfg_reg.back_ops        <= 9'd0;
            cfg_reg.write_block     <= 3'd0;
            cfg_reg.buffers_present <= 2'b11;
        end
        else if (cfg_wr)
        begin
            // Write only the bits each register holds; drop writes past the last one.
            unique case (cfg_idx)
                REG_STENCIL_ENABLE:  cfg_reg.stencil_enable  <= pwdata[0];
                REG_STENCIL_FUNC:    cfg_reg.stencil_func    <= sfunc_t'(pwdata[2:0]);
                REG_STENCIL_REF:     cfg_reg.stencil_ref     <= pwdata[7:0];
                REG_FRONT_OPS:       cfg_reg.front_ops       <= pwdata[8:0];
                REG_BACK_OPS:        cfg_reg.back_ops        <= pwdata[8:0];
                REG_WRITE_BLOCK:     cfg_reg.write_block     <= pwdata[2:0];
                REG_BUFFERS_PRESENT: cfg_reg.buffers_present <= pwdata[1:0];
                default:             ;
            endcase
        end
    end

    // Read back: zero-extend each register, zero past the list.
    always_comb
    begin
        unique case (cfg_idx)
            REG_STENCIL_ENABLE:  prdata = {{(APB_DATA_BITS-1){1'b0}}, cfg_reg.stencil_enable};
            REG_STENCIL_FUNC:    prdata = {{(APB_DATA_BITS-3){1'b0}}, cfg_reg.stencil_func};
            REG_STENCIL_REF:     prdata = {{(APB_DATA_BITS-8){1'b0}}, cfg_reg.stencil_ref};
            REG_FRONT_OPS:       prdata = {{(APB_DATA_BITS-9){1'b0}}, cfg_reg.front_ops};
            REG_BACK_OPS:        prdata = {{(APB_DATA_BITS-9){1'b0}}, cfg_reg.back_ops};
            REG_WRITE_BLOCK:     prdata = {{(APB_DATA_BITS-3){1'b0}}, cfg_reg.write_block};
            REG_BUFFERS_PRESENT: prdata = {{(APB_DATA_BITS-2){1'b0}}, cfg_reg.buffers_present};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    //   Stage 1 holds the accepted fragment; stage 2 holds the finished
    //   result. The result stage advances when empty or drained; stage 1
    //   frees up whenever its beat moves on, so a beat enters every cycle
    //   the result side keeps up.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance_out;
    logic in_accept;

    assign advance_out = ~out_valid_reg | out_ready;
    assign in_ready    = ~s1_valid_reg | advance_out;
    assign in_accept   = in_valid & in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance_out)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register (payload, no reset)
    // ------------------------------------------------------------------
    logic [7:0]                   stencil_reg;
    logic signed [DEPTH_BITS-1:0] stored_depth_reg;
    logic signed [DEPTH_BITS-1:0] frag_depth_reg;
    logic                         front_reg;
    logic                         discard_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stencil_reg      <= stored_stencil;
            stored_depth_reg <= stored_depth;
            frag_depth_reg   <= frag_depth;
            front_reg        <= front_facing;
            discard_reg      <= shader_discard;
        end
    end

    // ------------------------------------------------------------------
    // Tests and stencil update between the two registers
    // ------------------------------------------------------------------
    sdft_result_t res_next;
    sdft_result_t res_reg;

    sdft_eval #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_eval (
        .cfg            (cfg_reg),
        .stored_stencil (stencil_reg),
        .stored_depth   (stored_depth_reg),
        .frag_depth     (frag_depth_reg),
        .front_facing   (front_reg),
        .shader_discard (discard_reg),
        .res            (res_next)
    );

    // Stage 2: result register; load only when stage 1 hands a beat over.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance_out)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fate          = res_reg.fate;
    assign new_stencil   = res_reg.new_stencil;
    assign stencil_write = res_reg.stencil_write;
    assign depth_write   = res_reg.depth_write;
    assign color_write   = res_reg.color_write;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Only written fragments may touch depth or colour.
    `SDFT_ASSERT_NOW(a_no_write_unless_written,
        out_valid_reg && (res_reg.fate != FATE_WRITTEN),
        !res_reg.depth_write && !res_reg.color_write)
    // A stencil write needs an enabled test, a stencil buffer and no block.
    `SDFT_ASSERT_NOW(a_stencil_write_allowed,
        out_valid_reg && res_reg.stencil_write,
        cfg_reg.stencil_enable && cfg_reg.buffers_present[BP_STENCIL]
            && !cfg_reg.write_block[WB_STENCIL])
    // Never accept a beat while both stages are full and the output stalls.
    `SDFT_ASSERT_NOW(a_no_overrun,
        in_accept,
        !(s1_valid_reg && out_valid_reg && !out_ready))
    // A beat in stage 1 with a free result side shows up as a result next cycle.
    `SDFT_ASSERT_NEXT(a_beat_lands,
        s1_valid_reg && advance_out,
        out_valid_reg)

endmodule

`default_nettype wire

@@ rtl/core/sdft_eval.sv @@
`default_nettype none

module sdft_eval #(
    parameter int DEPTH_BITS = sdft_pkg::DEPTH_BITS_DEF
) (
    input  var sdft_pkg::sdft_cfg_t       cfg,
    input  wire logic [7:0]               stored_stencil,
    input  wire logic signed [DEPTH_BITS-1:0] stored_depth,
    input  wire logic signed [DEPTH_BITS-1:0] frag_depth,
    input  wire logic                     front_facing,
    input  wire logic                     shader_discard,
    output var sdft_pkg::sdft_result_t    res
);
    import sdft_pkg::*;

    logic       has_stencil;
    logic       has_depth;
    logic       ops_on;
    logic [8:0] ops;
    logic [7:0] sv;
    logic       stencil_fail;
    logic       depth_fail;

    assign has_stencil  = cfg.buffers_present[BP_STENCIL];
    assign has_depth    = cfg.buffers_present[BP_DEPTH];
    assign ops_on       = cfg.stencil_enable & has_stencil;
    assign ops          = front_facing ? cfg.front_ops : cfg.back_ops;
    assign sv           = has_stencil ? stored_stencil : 8'd0;
    assign stencil_fail = ops_on & ~stencil_compare(sv, cfg.stencil_ref, cfg.stencil_func);
    // Pass only on strictly nearer fragments.
    assign depth_fail   = has_depth & ~(frag_depth < stored_depth);

    always_comb
    begin
        res.fate          = FATE_WRITTEN;
        res.new_stencil   = sv;
        res.stencil_write = 1'b0;
        res.depth_write   = 1'b0;
        res.color_write   = 1'b0;
        priority if (stencil_fail)
        begin
            res.fate          = FATE_STENCIL_FAIL;
            res.new_stencil   = stencil_apply(sv, sop_t'(ops[2:0]), cfg.stencil_ref);
            res.stencil_write = 1'b1;
        end
        else if (depth_fail)
        begin
            res.fate = FATE_DEPTH_FAIL;
            if (ops_on)
            begin
                res.new_stencil   = stencil_apply(sv, sop_t'(ops[5:3]), cfg.stencil_ref);
                res.stencil_write = 1'b1;
            end
        end
        else if (shader_discard)
        begin
            res.fate = FATE_DISCARDED;
        end
        else
        begin
            res.fate = FATE_WRITTEN;
            if (ops_on)
            begin
                res.new_stencil   = stencil_apply(sv, sop_t'(ops[8:6]), cfg.stencil_ref);
                res.stencil_write = 1'b1;
            end
            res.depth_write = has_depth & ~cfg.write_block[WB_DEPTH];
            res.color_write = ~cfg.write_block[WB_COLOR];
        end
        if (cfg.write_block[WB_STENCIL])
        begin
            res.stencil_write = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/stencil_depth_fragment_checker.sv @@
`timescale 1ns / 100ps

module stencil_depth_fragment_checker #(
    parameter int DEPTH_BITS = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [sdft_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  wire logic [sdft_pkg::APB_DATA_BITS-1:0]     pwdata,
    input  wire logic [sdft_pkg::APB_DATA_BITS-1:0]     prdata,
    input  wire logic                                   pready,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_ready,
    input  wire logic [7:0]                             stored_stencil,
    input  wire logic signed [DEPTH_BITS-1:0]           stored_depth,
    input  wire logic signed [DEPTH_BITS-1:0]           frag_depth,
    input  wire logic                                   front_facing,
    input  wire logic                                   shader_discard,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_ready,
    input  wire logic [1:0]                             fate,
    input  wire logic [7:0]                             new_stencil,
    input  wire logic                                   stencil_write,
    input  wire logic                                   depth_write,
    input  wire logic                                   color_write,
    output int                                          fail_count,
    output int                                          pending
);

    import sdft_pkg::*;

    sdft_cfg_t    shadow_cfg;
    sdft_result_t expected_fates[$];

    function automatic logic stencil_passes(logic [7:0] s, logic [7:0] r, sfunc_t fn);
        case (fn)
            FUNC_NEVER:    return 1'b0;
            FUNC_LESS:     return s < r;
            FUNC_LEQUAL:   return !(s > r);
            FUNC_GREATER:  return s > r;
            FUNC_GEQUAL:   return !(s < r);
            FUNC_EQUAL:    return s == r;
            FUNC_NOTEQUAL: return s != r;
            default:       return 1'b1;
        endcase
    endfunction

    function automatic logic [7:0] next_stencil(logic [7:0] cur, sop_t op, logic [7:0] r);
        logic [8:0] up;
        up = {1'b0, cur} + 9'd1;
        case (op)
            OP_KEEP:      return cur;
            OP_ZERO:      return 8'd0;
            OP_REPLACE:   return r;
            OP_INCR:      return up[8] ? 8'hFF : up[7:0];
            OP_INCR_WRAP: return up[7:0];
            OP_DECR:      return (cur == 8'd0) ? 8'd0 : cur - 8'd1;
            OP_DECR_WRAP: return cur + 8'hFF;
            default:      return cur ^ 8'hFF;
        endcase
    endfunction

    function automatic sdft_result_t predict_fate(
        sdft_cfg_t c, logic [7:0] ss, logic signed [DEPTH_BITS-1:0] sd,
        logic signed [DEPTH_BITS-1:0] fd, logic ff, logic disc);
        sdft_result_t res;
        logic         has_s;
        logic         has_d;
        logic         ops_on;
        logic [8:0]   ops;
        logic [7:0]   sv;
        has_s  = c.buffers_present[BP_STENCIL];
        has_d  = c.buffers_present[BP_DEPTH];
        ops_on = c.stencil_enable && has_s;
        ops    = ff ? c.front_ops : c.back_ops;
        sv     = has_s ? ss : 8'd0;
        res    = '0;
        if (ops_on && !stencil_passes(sv, c.stencil_ref, c.stencil_func)) begin
            res.fate          = FATE_STENCIL_FAIL;
            sv                = next_stencil(sv, sop_t'(ops[2:0]), c.stencil_ref);
            res.stencil_write = 1'b1;
        end else if (has_d && !($signed(fd) < $signed(sd))) begin
            res.fate = FATE_DEPTH_FAIL;
            if (ops_on) begin
                sv                = next_stencil(sv, sop_t'(ops[5:3]), c.stencil_ref);
                res.stencil_write = 1'b1;
            end
        end else if (disc) begin
            res.fate = FATE_DISCARDED;
        end else begin
            res.fate = FATE_WRITTEN;
            if (ops_on) begin
                sv                = next_stencil(sv, sop_t'(ops[8:6]), c.stencil_ref);
                res.stencil_write = 1'b1;
            end
            res.depth_write = has_d && !c.write_block[WB_DEPTH];
            res.color_write = !c.write_block[WB_COLOR];
        end
        if (c.write_block[WB_STENCIL])
            res.stencil_write = 1'b0;
        res.new_stencil = sv;
        return res;
    endfunction

    function automatic logic [APB_DATA_BITS-1:0] shadow_value(int idx);
        case (idx)
            REG_STENCIL_ENABLE:  return APB_DATA_BITS'(shadow_cfg.stencil_enable);
            REG_STENCIL_FUNC:    return APB_DATA_BITS'(shadow_cfg.stencil_func);
            REG_STENCIL_REF:     return APB_DATA_BITS'(shadow_cfg.stencil_ref);
            REG_FRONT_OPS:       return APB_DATA_BITS'(shadow_cfg.front_ops);
            REG_BACK_OPS:        return APB_DATA_BITS'(shadow_cfg.back_ops);
            REG_WRITE_BLOCK:     return APB_DATA_BITS'(shadow_cfg.write_block);
            default:             return APB_DATA_BITS'(shadow_cfg.buffers_present);
        endcase
    endfunction

    task automatic check_field(string what, int want, int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int           idx;
        sdft_result_t want;
        if (!rst_n) begin
            shadow_cfg.stencil_enable  = 1'b0;
            shadow_cfg.stencil_func    = FUNC_ALWAYS;
            shadow_cfg.stencil_ref     = 8'd0;
            shadow_cfg.front_ops       = 9'd0;
            shadow_cfg.back_ops        = 9'd0;
            shadow_cfg.write_block     = 3'd0;
            shadow_cfg.buffers_present = 2'd3;
            expected_fates.delete();
        end else begin
            idx = int'(paddr[APB_ADDR_BITS-1:2]);
            if (psel && penable && pready && idx <= REG_BUFFERS_PRESENT) begin
                if (pwrite) begin
                    case (idx)
                        REG_STENCIL_ENABLE:  shadow_cfg.stencil_enable = pwdata[0];
                        REG_STENCIL_FUNC:    shadow_cfg.stencil_func = sfunc_t'(pwdata[2:0]);
                        REG_STENCIL_REF:     shadow_cfg.stencil_ref = pwdata[7:0];
                        REG_FRONT_OPS:       shadow_cfg.front_ops = pwdata[8:0];
                        REG_BACK_OPS:        shadow_cfg.back_ops = pwdata[8:0];
                        REG_WRITE_BLOCK:     shadow_cfg.write_block = pwdata[2:0];
                        default:             shadow_cfg.buffers_present = pwdata[1:0];
                    endcase
                end else begin
                    check_field($sformatf("readback of register %0d", idx),
                                shadow_value(idx), prdata);
                end
            end
            if (out_valid && out_ready) begin
                if (expected_fates.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat expected none, got fate %0d stencil %0d",
                             $time, fate, new_stencil);
                end else begin
                    want = expected_fates.pop_front();
                    check_field("fate", want.fate, fate);
                    check_field("new_stencil", want.new_stencil, new_stencil);
                    check_field("stencil_write", want.stencil_write, stencil_write);
                    check_field("depth_write", want.depth_write, depth_write);
                    check_field("color_write", want.color_write, color_write);
                end
            end
            if (in_valid && in_ready)
                expected_fates.push_back(predict_fate(shadow_cfg, stored_stencil,
                    stored_depth, frag_depth, front_facing, shader_discard));
        end
        pending = expected_fates.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

endmodule

@@ tb/sv/stencil_depth_fragment_test_test.sv @@
`timescale 1ns / 100ps

module stencil_depth_fragment_test_test;

    import sdft_pkg::*;

    localparam int DEPTH_BITS   = 24;
    // Leave a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 200000;
    // Long receiver hold-off used to fill the two-entry pipeline.
    localparam int HOLD_CYCLES  = 300;
    // Extra settle time after the last result before touching registers.
    localparam int DRAIN_CYCLES = 8;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_ADDR_BITS-1:0]      paddr;
    logic [APB_DATA_BITS-1:0]      pwdata;
    logic [APB_DATA_BITS-1:0]      prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic [7:0]                    stored_stencil;
    logic signed [DEPTH_BITS-1:0]  stored_depth;
    logic signed [DEPTH_BITS-1:0]  frag_depth;
    logic                          front_facing;
    logic                          shader_discard;
    logic                          out_valid;
    logic                          out_ready;
    logic [1:0]                    fate;
    logic [7:0]                    new_stencil;
    logic                          stencil_write;
    logic                          depth_write;
    logic                          color_write;

    int        fail_count;
    int        pending;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        beats_sent;
    int        settings_count;
    logic      hold_go;
    logic      hold_done;
    int        hold_count;
    sdft_cfg_t active_cfg;

    stencil_depth_fragment_test #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stored_stencil (stored_stencil),
        .stored_depth   (stored_depth),
        .frag_depth     (frag_depth),
        .front_facing   (front_facing),
        .shader_discard (shader_discard),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fate           (fate),
        .new_stencil    (new_stencil),
        .stencil_write  (stencil_write),
        .depth_write    (depth_write),
        .color_write    (color_write)
    );

    // Watch both channels and the register port; predict and compare there.
    stencil_depth_fragment_checker #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stored_stencil (stored_stencil),
        .stored_depth   (stored_depth),
        .frag_depth     (frag_depth),
        .front_facing   (front_facing),
        .shader_discard (shader_discard),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fate           (fate),
        .new_stencil    (new_stencil),
        .stencil_write  (stencil_write),
        .depth_write    (depth_write),
        .color_write    (color_write),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: abort the run if the block hangs.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: stall at random, except during the one long hold-off,
    // which this process counts out by itself while the sender keeps offering.
    initial
    begin
        out_ready  = 1'b0;
        hold_done  = 1'b0;
        hold_count = 0;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                out_ready  = 1'b0;
                hold_count = hold_count + 1;
                if (hold_count >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end else begin
                out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Register write: setup cycle, then access cycle; written at the edge
    // where the access phase meets pready.
    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Register read; the checker compares prdata against its own copy.
    task automatic read_reg(reg_idx_t idx);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic read_all_regs();
        for (int i = REG_STENCIL_ENABLE; i <= REG_BUFFERS_PRESENT; i++)
            read_reg(reg_idx_t'(i));
    endtask

    // Load a full register setting and read it back.
    task automatic program_settings(sdft_cfg_t c);
        write_reg(REG_STENCIL_ENABLE, APB_DATA_BITS'(c.stencil_enable));
        write_reg(REG_STENCIL_FUNC, APB_DATA_BITS'(c.stencil_func));
        write_reg(REG_STENCIL_REF, APB_DATA_BITS'(c.stencil_ref));
        write_reg(REG_FRONT_OPS, APB_DATA_BITS'(c.front_ops));
        write_reg(REG_BACK_OPS, APB_DATA_BITS'(c.back_ops));
        write_reg(REG_WRITE_BLOCK, APB_DATA_BITS'(c.write_block));
        write_reg(REG_BUFFERS_PRESENT, APB_DATA_BITS'(c.buffers_present));
        read_all_regs();
        active_cfg     = c;
        settings_count = settings_count + 1;
    endtask

    // Offer one fragment beat; valid stays up with the payload held until
    // the beat is taken. Valid is left high so back-to-back beats follow.
    task automatic send_fragment(logic [7:0] ss, logic [DEPTH_BITS-1:0] sd,
                                 logic [DEPTH_BITS-1:0] fd, logic ff, logic disc);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        stored_stencil = ss;
        stored_depth   = sd;
        frag_depth     = fd;
        front_facing   = ff;
        shader_discard = disc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        beats_sent = beats_sent + 1;
    endtask

    // Drop valid and wait until every result is back, plus DRAIN_CYCLES more.
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Pick a register setting: sometimes all-low or all-high extremes,
    // otherwise random with stencil mostly enabled and both buffers mostly present.
    function automatic sdft_cfg_t pick_settings();
        sdft_cfg_t c;
        int        mode;
        mode = $urandom_range(7);
        if (mode == 0) begin
            c.stencil_enable  = 1'b0;
            c.stencil_func    = FUNC_NEVER;
            c.stencil_ref     = 8'd0;
            c.front_ops       = 9'd0;
            c.back_ops        = 9'd0;
            c.write_block     = 3'd0;
            c.buffers_present = 2'd0;
        end else if (mode == 1) begin
            c.stencil_enable  = 1'b1;
            c.stencil_func    = FUNC_ALWAYS;
            c.stencil_ref     = 8'hFF;
            c.front_ops       = 9'h1FF;
            c.back_ops        = 9'h1FF;
            c.write_block     = 3'd7;
            c.buffers_present = 2'd3;
        end else begin
            c.stencil_enable  = ($urandom_range(3) != 0);
            c.stencil_func    = sfunc_t'($urandom_range(7));
            c.stencil_ref     = 8'($urandom_range(255));
            c.front_ops       = 9'($urandom);
            c.back_ops        = 9'($urandom);
            c.write_block     = ($urandom_range(1) == 0) ? 3'd0 : 3'($urandom);
            c.buffers_present = ($urandom_range(3) == 0) ? 2'($urandom) : 2'd3;
        end
        return c;
    endfunction

    // Random fragment, biased toward the compare and depth boundaries.
    task automatic send_random_fragment();
        logic [7:0]            ss;
        logic [DEPTH_BITS-1:0] sd;
        logic [DEPTH_BITS-1:0] fd;
        case ($urandom_range(7))
            0:       ss = active_cfg.stencil_ref;
            1:       ss = 8'd0;
            2:       ss = 8'hFF;
            3:       ss = active_cfg.stencil_ref + ($urandom_range(1) ? 8'd1 : 8'hFF);
            default: ss = 8'($urandom);
        endcase
        sd = DEPTH_BITS'($urandom);
        case ($urandom_range(7))
            0:       fd = sd;
            1:       fd = DEPTH_BITS'(sd + ($urandom_range(1) ? 1 : -1));
            2:       begin sd = DEPTH_MAX; fd = DEPTH_MIN; end
            3:       begin sd = DEPTH_MIN; fd = DEPTH_MAX; end
            default: fd = DEPTH_BITS'($urandom);
        endcase
        send_fragment(ss, sd, fd, 1'($urandom), ($urandom_range(3) == 0));
    endtask

    task automatic run_random_block(int n);
        repeat (n)
            send_random_fragment();
        drain();
    endtask

    initial
    begin
        sdft_cfg_t  c;
        logic [2:0] op_a;
        logic [2:0] op_b;
        logic [2:0] op_c;

        // Hold every input at a known value through reset.
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        stored_stencil = '0;
        stored_depth   = '0;
        frag_depth     = '0;
        front_facing   = 1'b0;
        shader_discard = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b0;
        beats_sent     = 0;
        settings_count = 0;

        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Confirm the reset values of every register.
        read_all_regs();

        // Directed: one setting per compare function, ops rotated so each op
        // lands in every slot of both faces; buffers and write blocks varied
        // to hit the missing-stencil, missing-depth and disabled cases.
        for (int k = 0; k < 8; k++) begin
            op_a                = 3'(k);
            op_b                = 3'(k + 1);
            op_c                = 3'(k + 2);
            c.stencil_enable    = (k != 3);
            c.stencil_func      = sfunc_t'(k);
            c.stencil_ref       = (k == 7) ? 8'hFF : 8'(k * 36);
            c.front_ops         = {op_c, op_b, op_a};
            c.back_ops          = {op_a, op_c, op_b};
            c.write_block       = 3'(k);
            c.buffers_present   = (k == 2) ? 2'd2 : (k == 5) ? 2'd1 : (k == 6) ? 2'd0 : 2'd3;
            program_settings(c);
            // Depth passes at full range, fails at full range, then a discard
            // just below the stored depth with the stencil at the reference.
            send_fragment(8'd0, DEPTH_MAX, DEPTH_MIN, 1'b1, 1'b0);
            send_fragment(8'hFF, DEPTH_MIN, DEPTH_MAX, 1'b0, 1'b0);
            send_fragment(c.stencil_ref, '0, '1, 1'(k), 1'b1);
            drain();
        end

        // Random: four idle mixes, four settings each.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            repeat (4) begin
                program_settings(pick_settings());
                run_random_block(45);
            end
        end

        // Backpressure: sender at full rate while the receiver holds off,
        // so the pipeline fills and in_ready drops.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_settings(pick_settings());
        hold_go = 1'b1;
        run_random_block(180);

        $display("Sent %0d fragments under %0d register settings, every compare function,",
                 beats_sent, settings_count);
        $display("every stencil op per face and slot, idle, stall and long backpressure phases");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
